### hdl/wcc_pkg.sv
// ----------------------------------------------------------------------------
// wcc_pkg
// shared types and codes for the window compare clamp unit
// ----------------------------------------------------------------------------
package wcc_pkg;

    localparam int DATA_W = 16;
    localparam int OFS_W  = 4;
    localparam int BE_W   = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [OFS_W-1:0]  offset_t;
    typedef logic [BE_W-1:0]   byte_en_t;

    // access kind
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register offsets
    localparam offset_t OFS_BOUND_FIRST  = 4'h0;
    localparam offset_t OFS_BOUND_SECOND = 4'h1;
    localparam offset_t OFS_TEST_HIST    = 4'h2;
    localparam offset_t OFS_STATUS       = 4'h3;
    localparam offset_t OFS_HISTORY      = 4'h4;
    localparam offset_t OFS_BOUND_ALIAS  = 4'h5;
    localparam offset_t OFS_TEST_PLAIN   = 4'h6;
    localparam offset_t OFS_CLAMPED      = 4'h7;

    localparam word_t UNMAPPED_WORD = 16'hFFFF;

    // range status, read back in the top two bits of the status word
    typedef enum logic [1:0] {
        STATUS_INSIDE = 2'd0,
        STATUS_ABOVE  = 2'd1,
        STATUS_BELOW  = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        word_t   clamped;
    } cmp_result_t;

endpackage

### hdl/wcc_cmp.sv
// ----------------------------------------------------------------------------
// wcc_cmp
// signed window compare and clamp of one test value against two bounds
// ----------------------------------------------------------------------------
module wcc_cmp (
    input  wcc_pkg::word_t       bound_first,
    input  wcc_pkg::word_t       bound_second,
    input  wcc_pkg::word_t       test_value,
    output wcc_pkg::cmp_result_t result
);
    import wcc_pkg::*;

    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;

    assign a = $signed(bound_first);
    assign b = $signed(bound_second);
    assign v = $signed(test_value);

    // window edges in either bound order
    assign lo = (a < b) ? a : b;
    assign hi = (a > b) ? a : b;

    always_comb
    begin
        if (v < lo)
        begin
            result.status  = STATUS_BELOW;
            result.clamped = word_t'(lo);
        end
        else if (v > hi)
        begin
            result.status  = STATUS_ABOVE;
            result.clamped = word_t'(hi);
        end
        else
        begin
            result.status  = STATUS_INSIDE;
            result.clamped = test_value;
        end
    end

endmodule

### hdl/window_compare_clamp_unit.sv
// ----------------------------------------------------------------------------
// window_compare_clamp_unit
// bus-mapped signed window compare with clamp, status and inside history
// ----------------------------------------------------------------------------
// One bus access is an item on the request channel. Items go into an input
// register; in the next cycle a write updates the bounds, test value, status,
// clamped value and history, and a read loads its data into a result
// register that drives the response channel. Writes give no response item.
// A new item is accepted in every cycle, also while a read result waits on a
// stalled response, until the input register holds a read that cannot move
// on; a read's response valid rises as it moves into the result register.
// The compare and clamp use the merged register values of the same write, so
// a read that follows a write always sees its effect.
module window_compare_clamp_unit (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              kind,
    input  wcc_pkg::offset_t  reg_offset,
    input  wcc_pkg::word_t    write_data,
    input  wcc_pkg::byte_en_t byte_enable,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wcc_pkg::word_t    read_data
);
    import wcc_pkg::*;

    // replace only the enabled bytes
    function automatic word_t merge_bytes(word_t old, word_t data, byte_en_t be);
        word_t r;
        r[15:8] = be[1] ? data[15:8] : old[15:8];
        r[7:0]  = be[0] ? data[7:0]  : old[7:0];
        return r;
    endfunction

    // input register
    logic     s1_valid_reg;
    logic     s1_kind_reg;
    offset_t  s1_offset_reg;
    word_t    s1_data_reg;
    byte_en_t s1_be_reg;

    // result register
    logic     rsp_valid_reg;
    word_t    rsp_data_reg;
    word_t    rsp_data_next;

    // block state
    word_t    bound_first_reg, bound_first_next;
    word_t    bound_second_reg, bound_second_next;
    word_t    test_value_reg, test_value_next;
    status_t  status_reg, status_next;
    word_t    clamped_reg, clamped_next;
    logic [1:0] history_reg, history_next;

    logic        s1_is_write;
    logic        s1_is_read;
    logic        s1_advance;
    logic        accept;
    logic        recompare;
    cmp_result_t cmp;

    assign s1_is_write = s1_valid_reg && (s1_kind_reg == KIND_WRITE);
    assign s1_is_read  = s1_valid_reg && (s1_kind_reg == KIND_READ);

    // a write always retires; a read needs a free or draining result register
    assign s1_advance = s1_is_write || (s1_is_read && (!rsp_valid_reg || !rsp_stall));
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign accept     = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind;
            s1_offset_reg <= reg_offset;
            s1_data_reg   <= write_data;
            s1_be_reg     <= byte_enable;
        end
    end

    // write decode with merged values
    always_comb
    begin
        bound_first_next  = bound_first_reg;
        bound_second_next = bound_second_reg;
        test_value_next   = test_value_reg;
        recompare         = 1'b0;
        if (s1_is_write)
        begin
            case (s1_offset_reg)
                OFS_BOUND_FIRST:
                begin
                    bound_first_next = merge_bytes(bound_first_reg, s1_data_reg, s1_be_reg);
                    recompare        = 1'b1;
                end
                OFS_BOUND_SECOND:
                begin
                    bound_second_next = merge_bytes(bound_second_reg, s1_data_reg, s1_be_reg);
                    recompare         = 1'b1;
                end
                OFS_TEST_HIST, OFS_TEST_PLAIN:
                begin
                    test_value_next = merge_bytes(test_value_reg, s1_data_reg, s1_be_reg);
                    recompare       = 1'b1;
                end
                default:
                begin
                    recompare = 1'b0;
                end
            endcase
        end
    end

    wcc_cmp u_cmp (
        .bound_first  (bound_first_next),
        .bound_second (bound_second_next),
        .test_value   (test_value_next),
        .result       (cmp)
    );

    // status, clamp and history updates
    always_comb
    begin
        status_next  = recompare ? cmp.status  : status_reg;
        clamped_next = recompare ? cmp.clamped : clamped_reg;
        history_next = history_reg;
        if (s1_is_write && (s1_offset_reg == OFS_TEST_HIST))
        begin
            // shift in the inside flag of this compare
            history_next = {history_reg[0], (cmp.status == STATUS_INSIDE)};
        end
        else if (s1_is_write && (s1_offset_reg == OFS_HISTORY))
        begin
            // cleared whatever the byte enables
            history_next = 2'b00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_first_reg  <= '0;
            bound_second_reg <= '0;
            test_value_reg   <= '0;
            status_reg       <= STATUS_INSIDE;
            clamped_reg      <= '0;
            history_reg      <= 2'b00;
        end
        else
        begin
            bound_first_reg  <= bound_first_next;
            bound_second_reg <= bound_second_next;
            test_value_reg   <= test_value_next;
            status_reg       <= status_next;
            clamped_reg      <= clamped_next;
            history_reg      <= history_next;
        end
    end

    // read decode
    always_comb
    begin
        case (s1_offset_reg)
            OFS_BOUND_FIRST:                  rsp_data_next = bound_first_reg;
            OFS_BOUND_SECOND, OFS_BOUND_ALIAS: rsp_data_next = bound_second_reg;
            OFS_TEST_HIST, OFS_TEST_PLAIN:    rsp_data_next = test_value_reg;
            OFS_STATUS:                       rsp_data_next = {status_reg, 14'd0};
            OFS_HISTORY:                      rsp_data_next = {14'd0, history_reg};
            OFS_CLAMPED:                      rsp_data_next = clamped_reg;
            default:                          rsp_data_next = UNMAPPED_WORD;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_is_read && s1_advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_is_read && s1_advance)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_data = rsp_data_reg;

endmodule
